/* hdl/rrsp_pkg.sv */
// shared types and constants of the reply stream parser
`default_nettype none
package rrsp_pkg;

  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  localparam logic [3:0] EV_STATUS_BYTE = 4'd0;
  localparam logic [3:0] EV_ERROR_BYTE  = 4'd1;
  localparam logic [3:0] EV_STATUS_END  = 4'd2;
  localparam logic [3:0] EV_ERROR_END   = 4'd3;
  localparam logic [3:0] EV_INTEGER     = 4'd4;
  localparam logic [3:0] EV_BULK_HDR    = 4'd5;
  localparam logic [3:0] EV_BULK_BYTE   = 4'd6;
  localparam logic [3:0] EV_BULK_END    = 4'd7;
  localparam logic [3:0] EV_ARRAY_HDR   = 4'd8;
  localparam logic [3:0] EV_MALFORMED   = 4'd9;

  localparam int LEVEL_W = 5;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_FINISH,
    OP_PUSH,
    OP_RESTART
  } op_t;

  typedef struct packed {
    logic [3:0]  ev;
    logic [7:0]  text;
    logic [31:0] num;
    op_t         op;
  } token_t;

  typedef struct packed {
    logic [3:0]         ev;
    logic [7:0]         text;
    logic [31:0]        num;
    logic [LEVEL_W-1:0] level;
    logic               done;
  } result_t;

endpackage
`default_nettype wire

/* hdl/rrsp_ram.sv */
// generic single-port-write ram with registered read
`default_nettype none
module rrsp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  wen,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* hdl/rrsp_fifo.sv */
// small register queue
`default_nettype none
module rrsp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] data_in,
  output logic                  full,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] data_out,
  output logic                  empty
);

  localparam int PW = DEPTH > 1 ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full     = count == CW'(DEPTH);
  assign empty    = count == '0;
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign data_out = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        slots[wr_ptr] <= data_in;
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

/* hdl/rrsp_front.sv */
// byte lexer: line phases, header number parsing, token generation
`default_nettype none
module rrsp_front (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        accept,
  input  wire logic [7:0]  stream_byte,
  output logic             tok_valid,
  output rrsp_pkg::token_t tok
);

  typedef enum logic [2:0] {
    PH_TYPE, PH_TEXT, PH_NUM_START, PH_NUM_DIGITS,
    PH_NUM_SKIP, PH_LF, PH_BULK_DATA, PH_BULK_CR
  } phase_t;

  typedef enum logic [2:0] {
    LK_STATUS, LK_ERROR, LK_INTEGER, LK_BULK_HDR, LK_ARRAY_HDR, LK_BULK_END
  } kind_t;

  phase_t      phase, phase_next;
  kind_t       line_kind, line_kind_next;
  logic        negative, negative_next;
  logic [31:0] acc, acc_next;
  logic [31:0] payload_left, payload_left_next;
  logic [31:0] value;
  logic [31:0] left_dec;
  logic        is_digit;
  logic        emit;
  rrsp_pkg::token_t t;

  assign value    = negative ? (32'd0 - acc) : acc;
  assign left_dec = (payload_left == '0) ? '0 : payload_left - 1'b1;
  assign is_digit = stream_byte >= rrsp_pkg::CH_ZERO && stream_byte <= rrsp_pkg::CH_NINE;

  always_comb begin
    phase_next        = phase;
    line_kind_next    = line_kind;
    negative_next     = negative;
    acc_next          = acc;
    payload_left_next = payload_left;
    emit              = 1'b0;
    t                 = '{ev: rrsp_pkg::EV_MALFORMED, text: 8'd0, num: 32'd0,
                          op: rrsp_pkg::OP_RESTART};
    case (phase)
      PH_TYPE: begin
        negative_next = 1'b0;
        acc_next      = '0;
        case (stream_byte)
          rrsp_pkg::CH_PLUS: begin
            line_kind_next = LK_STATUS;
            phase_next     = PH_TEXT;
          end
          rrsp_pkg::CH_MINUS: begin
            line_kind_next = LK_ERROR;
            phase_next     = PH_TEXT;
          end
          rrsp_pkg::CH_COLON: begin
            line_kind_next = LK_INTEGER;
            phase_next     = PH_NUM_START;
          end
          rrsp_pkg::CH_DOLLAR: begin
            line_kind_next = LK_BULK_HDR;
            phase_next     = PH_NUM_START;
          end
          rrsp_pkg::CH_STAR: begin
            line_kind_next = LK_ARRAY_HDR;
            phase_next     = PH_NUM_START;
          end
          default: begin
            emit              = 1'b1;
            line_kind_next    = LK_STATUS;
            payload_left_next = '0;
          end
        endcase
      end
      PH_TEXT: begin
        if (stream_byte == rrsp_pkg::CH_CR) begin
          phase_next = PH_LF;
        end else begin
          emit   = 1'b1;
          t.ev   = (line_kind == LK_ERROR) ? rrsp_pkg::EV_ERROR_BYTE
                                           : rrsp_pkg::EV_STATUS_BYTE;
          t.text = stream_byte;
          t.op   = rrsp_pkg::OP_NONE;
        end
      end
      PH_NUM_START, PH_NUM_DIGITS, PH_NUM_SKIP: begin
        if (stream_byte == rrsp_pkg::CH_CR) begin
          phase_next = PH_LF;
        end else if (phase != PH_NUM_SKIP) begin
          if (is_digit) begin
            acc_next   = (acc << 3) + (acc << 1) + {24'd0, stream_byte - rrsp_pkg::CH_ZERO};
            phase_next = PH_NUM_DIGITS;
          end else if (phase == PH_NUM_START && stream_byte == rrsp_pkg::CH_MINUS) begin
            negative_next = 1'b1;
            phase_next    = PH_NUM_DIGITS;
          end else begin
            phase_next = PH_NUM_SKIP;
          end
        end
      end
      PH_BULK_DATA: begin
        payload_left_next = left_dec;
        if (left_dec == '0) begin
          phase_next = PH_BULK_CR;
        end
        emit   = 1'b1;
        t.ev   = rrsp_pkg::EV_BULK_BYTE;
        t.text = stream_byte;
        t.op   = rrsp_pkg::OP_NONE;
      end
      PH_BULK_CR: begin
        if (stream_byte == rrsp_pkg::CH_CR) begin
          line_kind_next = LK_BULK_END;
          phase_next     = PH_LF;
        end else begin
          emit              = 1'b1;
          phase_next        = PH_TYPE;
          line_kind_next    = LK_STATUS;
          negative_next     = 1'b0;
          acc_next          = '0;
          payload_left_next = '0;
        end
      end
      default: begin
        emit       = 1'b1;
        phase_next = PH_TYPE;
        if (stream_byte != rrsp_pkg::CH_LF) begin
          line_kind_next    = LK_STATUS;
          negative_next     = 1'b0;
          acc_next          = '0;
          payload_left_next = '0;
        end else begin
          case (line_kind)
            LK_STATUS: begin
              t.ev = rrsp_pkg::EV_STATUS_END;
              t.op = rrsp_pkg::OP_FINISH;
            end
            LK_ERROR: begin
              t.ev = rrsp_pkg::EV_ERROR_END;
              t.op = rrsp_pkg::OP_FINISH;
            end
            LK_INTEGER: begin
              t.ev  = rrsp_pkg::EV_INTEGER;
              t.num = value;
              t.op  = rrsp_pkg::OP_FINISH;
            end
            LK_BULK_HDR: begin
              t.ev  = rrsp_pkg::EV_BULK_HDR;
              t.num = value;
              if (value[31]) begin
                t.op = rrsp_pkg::OP_FINISH;
              end else begin
                t.op              = rrsp_pkg::OP_NONE;
                payload_left_next = value;
                phase_next        = (value == '0) ? PH_BULK_CR : PH_BULK_DATA;
              end
            end
            LK_ARRAY_HDR: begin
              t.ev  = rrsp_pkg::EV_ARRAY_HDR;
              t.num = value;
              t.op  = (value[31] || value == '0) ? rrsp_pkg::OP_FINISH : rrsp_pkg::OP_PUSH;
            end
            LK_BULK_END: begin
              t.ev = rrsp_pkg::EV_BULK_END;
              t.op = rrsp_pkg::OP_FINISH;
            end
            default: begin
              line_kind_next    = LK_STATUS;
              negative_next     = 1'b0;
              acc_next          = '0;
              payload_left_next = '0;
            end
          endcase
        end
      end
    endcase
  end

  assign tok_valid = accept && emit;
  assign tok       = t;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_TYPE;
      line_kind    <= LK_STATUS;
      negative     <= 1'b0;
      acc          <= '0;
      payload_left <= '0;
    end else if (accept) begin
      phase        <= phase_next;
      line_kind    <= line_kind_next;
      negative     <= negative_next;
      acc          <= acc_next;
      payload_left <= payload_left_next;
    end
  end

endmodule
`default_nettype wire

/* hdl/rrsp_back.sv */
// nesting tracker: count stack, element completion, result generation
`default_nettype none
module rrsp_back #(
  parameter int MAX_DEPTH = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              tok_ready,
  input  wire rrsp_pkg::token_t  tok,
  output logic                   take,
  input  wire logic              res_full,
  output logic                   res_valid,
  output rrsp_pkg::result_t      res
);

  localparam int AW = MAX_DEPTH > 1 ? $clog2(MAX_DEPTH) : 1;
  localparam int DW = $clog2(MAX_DEPTH + 1);

  logic [DW-1:0]        depth, depth_next;
  logic [31:0]          top_cnt, top_cnt_next;
  logic [MAX_DEPTH-1:0] one_flags;
  logic                 loading, loading_next;
  logic                 found;
  logic [AW-1:0]        target;
  logic [AW-1:0]        top_idx;
  logic                 ram_wen;
  logic [31:0]          ram_rdata;
  rrsp_pkg::result_t    r;

  assign take      = tok_ready && !loading && !res_full;
  assign res_valid = take;
  assign top_idx   = AW'(depth - 1'b1);

  always_comb begin
    found  = 1'b0;
    target = '0;
    for (int i = 0; i < MAX_DEPTH - 1; i++) begin
      if (DW'(i + 1) < depth && !one_flags[i]) begin
        found  = 1'b1;
        target = AW'(i);
      end
    end
  end

  always_comb begin
    depth_next   = depth;
    top_cnt_next = top_cnt;
    loading_next = 1'b0;
    ram_wen      = 1'b0;
    r            = '{ev: tok.ev, text: tok.text, num: tok.num,
                     level: rrsp_pkg::LEVEL_W'(depth), done: 1'b0};
    if (loading) begin
      top_cnt_next = ram_rdata - 1'b1;
    end else if (take) begin
      case (tok.op)
        rrsp_pkg::OP_NONE: begin
        end
        rrsp_pkg::OP_RESTART: begin
          depth_next = '0;
        end
        rrsp_pkg::OP_FINISH: begin
          if (depth == '0) begin
            r.done = 1'b1;
          end else if (top_cnt != 32'd1) begin
            top_cnt_next = top_cnt - 1'b1;
          end else if (found) begin
            depth_next   = DW'(target) + 1'b1;
            loading_next = 1'b1;
          end else begin
            depth_next = '0;
            r.done     = 1'b1;
          end
        end
        default: begin
          if (depth >= DW'(MAX_DEPTH)) begin
            r.ev       = rrsp_pkg::EV_MALFORMED;
            r.num      = '0;
            depth_next = '0;
          end else begin
            ram_wen      = depth != '0;
            top_cnt_next = tok.num;
            depth_next   = depth + 1'b1;
          end
        end
      endcase
    end
  end

  assign res = r;

  rrsp_ram #(.WIDTH(32), .DEPTH(MAX_DEPTH)) u_stack (
    .clk  (clk),
    .wen  (ram_wen),
    .waddr(top_idx),
    .wdata(top_cnt),
    .raddr(target),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      depth     <= '0;
      top_cnt   <= '0;
      loading   <= 1'b0;
      one_flags <= '0;
    end else begin
      depth   <= depth_next;
      top_cnt <= top_cnt_next;
      loading <= loading_next;
      if (ram_wen) begin
        one_flags[top_idx] <= top_cnt == 32'd1;
      end
    end
  end

endmodule
`default_nettype wire

/* hdl/resp_reply_stream_parser.sv */
// top level of the reply stream parser
// usage:
//   input queue side: drive stream_byte with push high; a byte is taken at a
//   clock edge where push is high and full is low.
//   result queue side: while empty is low the oldest event sits on event_res,
//   text_byte, number, nest_level and reply_done; pop high takes it. each byte
//   yields zero or one event; known type, header and line-end CR bytes yield none.
// timing:
//   one byte per cycle sustained while pop keeps up. an event is registered in
//   the token queue by the lexer, then in the result queue by the tracker.
//   a completion that unwinds one or more array levels costs the tracker a
//   stall to reload the new top count from the stack ram; the token queue
//   absorbs it, as such completions are at least three bytes apart.
// reset:
//   synchronous rst empties both queues, returns to the type byte and clears
//   the nesting depth; stack ram contents need no clearing.
// stalls:
//   with pop low the result queue fills, the tracker stops, the token queue
//   fills and full rises; no transaction is lost or repeated.
`default_nettype none
module resp_reply_stream_parser #(
  parameter int MAX_DEPTH   = 16,
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  output logic                    full,
  input  wire logic [7:0]         stream_byte,
  output logic                    empty,
  input  wire logic               pop,
  output logic        [3:0]       event_res,
  output logic        [7:0]       text_byte,
  output logic signed [31:0]      number,
  output logic        [4:0]       nest_level,
  output logic                    reply_done
);

  localparam int TOK_W = $bits(rrsp_pkg::token_t);
  localparam int RES_W = $bits(rrsp_pkg::result_t);

  logic              accept;
  logic              tok_valid;
  rrsp_pkg::token_t  tok_in;
  rrsp_pkg::token_t  tok_out;
  logic              tok_empty;
  logic              take;
  logic              res_full;
  logic              res_valid;
  rrsp_pkg::result_t res_in;
  rrsp_pkg::result_t res_out;

  assign accept = push && !full;

  rrsp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .stream_byte(stream_byte),
    .tok_valid  (tok_valid),
    .tok        (tok_in)
  );

  rrsp_fifo #(.WIDTH(TOK_W), .DEPTH(QUEUE_DEPTH)) u_tok_q (
    .clk     (clk),
    .rst     (rst),
    .push    (tok_valid),
    .data_in (tok_in),
    .full    (full),
    .pop     (take),
    .data_out(tok_out),
    .empty   (tok_empty)
  );

  rrsp_back #(.MAX_DEPTH(MAX_DEPTH)) u_back (
    .clk      (clk),
    .rst      (rst),
    .tok_ready(!tok_empty),
    .tok      (tok_out),
    .take     (take),
    .res_full (res_full),
    .res_valid(res_valid),
    .res      (res_in)
  );

  rrsp_fifo #(.WIDTH(RES_W), .DEPTH(QUEUE_DEPTH)) u_res_q (
    .clk     (clk),
    .rst     (rst),
    .push    (res_valid),
    .data_in (res_in),
    .full    (res_full),
    .pop     (pop),
    .data_out(res_out),
    .empty   (empty)
  );

  assign event_res  = res_out.ev;
  assign text_byte  = res_out.text;
  assign number     = $signed(res_out.num);
  assign nest_level = res_out.level;
  assign reply_done = res_out.done;

endmodule
`default_nettype wire

/* hdl/rrsp_checker.sv */
// port-level assertions for the reply stream parser, bound to the top level
`default_nettype none
module rrsp_port_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               empty,
  input wire logic               full,
  input wire logic [3:0]         event_res,
  input wire logic [7:0]         text_byte,
  input wire logic signed [31:0] number,
  input wire logic               reply_done
);

  a_reset_empties: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("queues not empty after reset");

  a_event_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> event_res <= rrsp_pkg::EV_MALFORMED)
    else $error("event code out of range");

  a_text_only_bytes: assert property (@(posedge clk) disable iff (rst)
    (!empty && text_byte != 8'd0) |-> (event_res == rrsp_pkg::EV_STATUS_BYTE ||
      event_res == rrsp_pkg::EV_ERROR_BYTE || event_res == rrsp_pkg::EV_BULK_BYTE))
    else $error("text byte on a non-byte event");

  a_number_only_headers: assert property (@(posedge clk) disable iff (rst)
    (!empty && number != 32'sd0) |-> (event_res == rrsp_pkg::EV_INTEGER ||
      event_res == rrsp_pkg::EV_BULK_HDR || event_res == rrsp_pkg::EV_ARRAY_HDR))
    else $error("number on a non-header event");

  a_done_on_completion: assert property (@(posedge clk) disable iff (rst)
    (!empty && reply_done) |-> !(event_res == rrsp_pkg::EV_STATUS_BYTE ||
      event_res == rrsp_pkg::EV_ERROR_BYTE || event_res == rrsp_pkg::EV_BULK_BYTE ||
      event_res == rrsp_pkg::EV_MALFORMED))
    else $error("reply done on an event that completes nothing");

endmodule

bind resp_reply_stream_parser rrsp_port_checker u_rrsp_port_checker (
  .clk       (clk),
  .rst       (rst),
  .empty     (empty),
  .full      (full),
  .event_res (event_res),
  .text_byte (text_byte),
  .number    (number),
  .reply_done(reply_done)
);
`default_nettype wire

/* dv/rrsp_checker.sv */
// checker that predicts and compares the parser event stream
`timescale 1ns / 100ps
module rrsp_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  input  wire logic        full,
  input  wire logic [7:0]  stream_byte,
  input  wire logic        empty,
  input  wire logic        pop,
  input  wire logic [3:0]  event_res,
  input  wire logic [7:0]  text_byte,
  input  wire logic [31:0] number,
  input  wire logic [4:0]  nest_level,
  input  wire logic        reply_done,
  output int               errors,
  output int               pending
);

  localparam int STACK_DEPTH = 16;

  localparam logic [2:0] PH_TYPE       = 3'd0;
  localparam logic [2:0] PH_TEXT       = 3'd1;
  localparam logic [2:0] PH_NUM_START  = 3'd2;
  localparam logic [2:0] PH_NUM_DIGITS = 3'd3;
  localparam logic [2:0] PH_NUM_SKIP   = 3'd4;
  localparam logic [2:0] PH_LF         = 3'd5;
  localparam logic [2:0] PH_BULK_DATA  = 3'd6;
  localparam logic [2:0] PH_BULK_CR    = 3'd7;

  localparam logic [2:0] LK_STATUS    = 3'd0;
  localparam logic [2:0] LK_ERROR     = 3'd1;
  localparam logic [2:0] LK_INTEGER   = 3'd2;
  localparam logic [2:0] LK_BULK_HDR  = 3'd3;
  localparam logic [2:0] LK_ARRAY_HDR = 3'd4;
  localparam logic [2:0] LK_BULK_END  = 3'd5;

  logic [2:0]  ph;
  logic [2:0]  kind;
  logic        neg;
  logic [31:0] acc;
  logic [31:0] left;
  logic [31:0] count_stk [STACK_DEPTH];
  int unsigned depth;
  rrsp_pkg::result_t event_q [$];

  function automatic logic close_element();
    while (depth > 0 && depth <= STACK_DEPTH) begin
      count_stk[depth-1] = count_stk[depth-1] - 1;
      if (count_stk[depth-1] != 0) return 1'b0;
      depth--;
    end
    depth = 0;
    return 1'b1;
  endfunction

  function automatic void add_event(logic [3:0] ev, logic [7:0] t, logic [31:0] n,
                                    logic [4:0] lvl, logic d);
    rrsp_pkg::result_t r;
    r.ev = ev;
    r.text = t;
    r.num = n;
    r.level = lvl;
    r.done = d;
    event_q.push_back(r);
  endfunction

  function automatic void restart(logic [4:0] lvl);
    ph = PH_TYPE;
    kind = LK_STATUS;
    neg = 1'b0;
    acc = '0;
    left = '0;
    depth = 0;
    add_event(rrsp_pkg::EV_MALFORMED, 8'h00, 32'h0, lvl, 1'b0);
  endfunction

  function automatic void parse_byte(logic [7:0] b);
    logic [4:0]  lvl;
    logic [31:0] val;
    logic        d;
    lvl = depth[4:0];
    case (ph)
      PH_TYPE: begin
        neg = 1'b0;
        acc = '0;
        if (b == rrsp_pkg::CH_PLUS) begin
          kind = LK_STATUS; ph = PH_TEXT;
        end else if (b == rrsp_pkg::CH_MINUS) begin
          kind = LK_ERROR; ph = PH_TEXT;
        end else if (b == rrsp_pkg::CH_COLON) begin
          kind = LK_INTEGER; ph = PH_NUM_START;
        end else if (b == rrsp_pkg::CH_DOLLAR) begin
          kind = LK_BULK_HDR; ph = PH_NUM_START;
        end else if (b == rrsp_pkg::CH_STAR) begin
          kind = LK_ARRAY_HDR; ph = PH_NUM_START;
        end else begin
          restart(lvl);
        end
      end
      PH_TEXT: begin
        if (b == rrsp_pkg::CH_CR) ph = PH_LF;
        else add_event(kind == LK_ERROR ? rrsp_pkg::EV_ERROR_BYTE : rrsp_pkg::EV_STATUS_BYTE,
                       b, 32'h0, lvl, 1'b0);
      end
      PH_NUM_START, PH_NUM_DIGITS, PH_NUM_SKIP: begin
        if (b == rrsp_pkg::CH_CR) begin
          ph = PH_LF;
        end else if (ph != PH_NUM_SKIP) begin
          if (b >= rrsp_pkg::CH_ZERO && b <= rrsp_pkg::CH_NINE) begin
            acc = acc * 32'd10 + 32'(b - rrsp_pkg::CH_ZERO);
            ph = PH_NUM_DIGITS;
          end else if (ph == PH_NUM_START && b == rrsp_pkg::CH_MINUS) begin
            neg = 1'b1;
            ph = PH_NUM_DIGITS;
          end else begin
            ph = PH_NUM_SKIP;
          end
        end
      end
      PH_BULK_DATA: begin
        if (left > 0) left = left - 1;
        if (left == 0) ph = PH_BULK_CR;
        add_event(rrsp_pkg::EV_BULK_BYTE, b, 32'h0, lvl, 1'b0);
      end
      PH_BULK_CR: begin
        if (b != rrsp_pkg::CH_CR) begin
          restart(lvl);
        end else begin
          kind = LK_BULK_END;
          ph = PH_LF;
        end
      end
      default: begin
        if (b != rrsp_pkg::CH_LF) begin
          restart(lvl);
        end else begin
          val = neg ? -acc : acc;
          ph = PH_TYPE;
          case (kind)
            LK_STATUS: begin
              d = close_element();
              add_event(rrsp_pkg::EV_STATUS_END, 8'h00, 32'h0, lvl, d);
            end
            LK_ERROR: begin
              d = close_element();
              add_event(rrsp_pkg::EV_ERROR_END, 8'h00, 32'h0, lvl, d);
            end
            LK_INTEGER: begin
              d = close_element();
              add_event(rrsp_pkg::EV_INTEGER, 8'h00, val, lvl, d);
            end
            LK_BULK_HDR: begin
              if (val[31]) begin
                d = close_element();
                add_event(rrsp_pkg::EV_BULK_HDR, 8'h00, val, lvl, d);
              end else begin
                left = val;
                ph = (val == 0) ? PH_BULK_CR : PH_BULK_DATA;
                add_event(rrsp_pkg::EV_BULK_HDR, 8'h00, val, lvl, 1'b0);
              end
            end
            LK_ARRAY_HDR: begin
              if (val[31] || val == 0) begin
                d = close_element();
                add_event(rrsp_pkg::EV_ARRAY_HDR, 8'h00, val, lvl, d);
              end else if (depth >= STACK_DEPTH) begin
                restart(lvl);
              end else begin
                count_stk[depth] = val;
                depth++;
                add_event(rrsp_pkg::EV_ARRAY_HDR, 8'h00, val, lvl, 1'b0);
              end
            end
            LK_BULK_END: begin
              d = close_element();
              add_event(rrsp_pkg::EV_BULK_END, 8'h00, 32'h0, lvl, d);
            end
            default: restart(lvl);
          endcase
        end
      end
    endcase
  endfunction

  initial begin
    errors = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    rrsp_pkg::result_t w;
    if (rst) begin
      ph = PH_TYPE;
      kind = LK_STATUS;
      neg = 1'b0;
      acc = '0;
      left = '0;
      depth = 0;
      event_q.delete();
    end else begin
      if (pop && !empty) begin
        if (event_q.size() == 0) begin
          $display("%0t unexpected transaction: ev %0d text %h number %h level %0d done %0d",
                   $time, event_res, text_byte, number, nest_level, reply_done);
          errors++;
        end else begin
          w = event_q.pop_front();
          if (event_res !== w.ev) begin
            $display("%0t event: expected %0d actual %0d", $time, w.ev, event_res);
            errors++;
          end
          if (text_byte !== w.text) begin
            $display("%0t text_byte: expected %h actual %h", $time, w.text, text_byte);
            errors++;
          end
          if (number !== w.num) begin
            $display("%0t number: expected %h actual %h", $time, w.num, number);
            errors++;
          end
          if (nest_level !== w.level) begin
            $display("%0t nest_level: expected %0d actual %0d", $time, w.level, nest_level);
            errors++;
          end
          if (reply_done !== w.done) begin
            $display("%0t reply_done: expected %0d actual %0d", $time, w.done, reply_done);
            errors++;
          end
        end
      end
      if (push && !full) parse_byte(stream_byte);
    end
    pending = event_q.size();
  end

endmodule

/* dv/tb.sv */
// testbench top: byte stimulus, result draining and verdict for the reply parser
`timescale 1ns / 100ps
module tb;

  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic [7:0]  stream_byte = 8'h00;
  logic        pop = 1'b0;
  logic        full;
  logic        empty;
  logic [3:0]  event_res;
  logic [7:0]  text_byte;
  logic signed [31:0] number;
  logic [4:0]  nest_level;
  logic        reply_done;
  int          errors;
  int          pending;
  int          quiet = 0;
  int          pops = 0;
  logic [7:0]  byte_q [$];

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  resp_reply_stream_parser uut (
    .clk(clk), .rst(rst), .push(push), .full(full), .stream_byte(stream_byte),
    .empty(empty), .pop(pop), .event_res(event_res), .text_byte(text_byte),
    .number(number), .nest_level(nest_level), .reply_done(reply_done)
  );

  rrsp_checker chk (
    .clk(clk), .rst(rst), .push(push), .full(full), .stream_byte(stream_byte),
    .empty(empty), .pop(pop), .event_res(event_res), .text_byte(text_byte),
    .number(number), .nest_level(nest_level), .reply_done(reply_done),
    .errors(errors), .pending(pending)
  );

  task automatic put_str(string s);
    for (int i = 0; i < s.len(); i++) byte_q.push_back(s[i]);
  endtask

  task automatic put_crlf();
    byte_q.push_back(rrsp_pkg::CH_CR);
    byte_q.push_back(rrsp_pkg::CH_LF);
  endtask

  task automatic put_num(longint v);
    put_str($sformatf("%0d", v));
    put_crlf();
  endtask

  task automatic put_text();
    int n;
    logic [7:0] b;
    n = $urandom_range(0, 5);
    repeat (n) begin
      b = 8'($urandom);
      if (b == rrsp_pkg::CH_CR) b = 8'h00;
      byte_q.push_back(b);
    end
    put_crlf();
  endtask

  task automatic put_reply(int lvl);
    int sel;
    int n;
    sel = $urandom_range(0, 9);
    if (sel < 2) begin
      byte_q.push_back(rrsp_pkg::CH_PLUS);
      put_text();
    end else if (sel < 3) begin
      byte_q.push_back(rrsp_pkg::CH_MINUS);
      put_text();
    end else if (sel < 5) begin
      byte_q.push_back(rrsp_pkg::CH_COLON);
      case ($urandom_range(0, 3))
        0: put_num(longint'($signed(32'($urandom))));
        1: put_num(longint'({$urandom_range(0, 2), $urandom}) % 64'd99999999999);
        2: put_num(longint'($urandom_range(0, 99)) - 50);
        default: begin
          put_str($sformatf("%0d", $urandom_range(0, 999)));
          byte_q.push_back(8'($urandom));
          byte_q.push_back(rrsp_pkg::CH_ZERO);
          put_crlf();
        end
      endcase
    end else if (sel < 7 || lvl >= 4) begin
      byte_q.push_back(rrsp_pkg::CH_DOLLAR);
      if ($urandom_range(0, 7) == 0) begin
        put_num(-1);
      end else begin
        n = $urandom_range(0, 6);
        put_num(n);
        repeat (n) byte_q.push_back(8'($urandom));
        put_crlf();
      end
    end else begin
      byte_q.push_back(rrsp_pkg::CH_STAR);
      if ($urandom_range(0, 7) == 0) begin
        put_num($urandom_range(0, 1) ? 0 : -1);
      end else begin
        n = $urandom_range(1, 3);
        put_num(n);
        repeat (n) put_reply(lvl + 1);
      end
    end
  endtask

  task automatic put_directed();
    put_str("+OK"); put_crlf();
    put_str("-E"); put_crlf();
    put_str(":2147483647"); put_crlf();
    put_str(":-2147483648"); put_crlf();
    put_str(":4294967297"); put_crlf();
    put_str(":12x9"); put_crlf();
    put_str(":-"); put_crlf();
    put_str("$0"); put_crlf(); put_crlf();
    put_str("$-1"); put_crlf();
    put_str("$3"); put_crlf();
    byte_q.push_back(8'h00); byte_q.push_back(8'hFF); byte_q.push_back(rrsp_pkg::CH_CR);
    put_crlf();
    put_str("*0"); put_crlf();
    put_str("*-1"); put_crlf();
    put_str("*2"); put_crlf(); put_str(":1"); put_crlf();
    put_str("*1"); put_crlf(); put_str("+A"); put_crlf();
    repeat (17) begin
      put_str("*1"); put_crlf();
    end
    put_str("?");
    put_str("+x"); byte_q.push_back(rrsp_pkg::CH_CR); put_str("Q");
    put_str("$1"); put_crlf(); put_str("AB");
    put_str("*3"); put_crlf(); put_str(":5"); put_str("Z");
  endtask

  task automatic send_byte(logic [7:0] b, int gap);
    if (gap > 0) begin
      push = 1'b0;
      repeat (gap) @(negedge clk);
    end
    push = 1'b1;
    stream_byte = b;
    @(posedge clk);
    while (full) @(posedge clk);
    @(negedge clk);
  endtask

  // result side: random pop gaps, bursts and one long hold-off
  initial begin
    int gap;
    bit burst;
    burst = 1'b0;
    @(negedge rst);
    @(negedge clk);
    forever begin
      if (pops % 100 == 0) burst = ($urandom_range(0, 3) == 0);
      gap = burst ? 0 : $urandom_range(0, 7);
      if (pops == 400) gap = HOLD_CYCLES;
      if (gap > 0) begin
        pop = 1'b0;
        repeat (gap) @(negedge clk);
      end
      pop = 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
      pops++;
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((push && !full) || (pop && !empty)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    int sent;
    int gap;
    bit burst;
    burst = 1'b0;
    sent = 0;
    put_directed();
    while (byte_q.size() < 1700) begin
      if ($urandom_range(0, 19) == 0) begin
        repeat ($urandom_range(1, 4)) byte_q.push_back(8'($urandom));
      end else begin
        put_reply(0);
      end
    end
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    foreach (byte_q[i]) begin
      if (sent % 150 == 0) burst = ($urandom_range(0, 3) == 0);
      gap = burst ? 0 : $urandom_range(0, 7);
      send_byte(byte_q[i], gap);
      sent++;
    end
    push = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
